@@ rtl/km2d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package km2d_pkg;

	localparam int MAX_POINTS   = 1024;
	localparam int PT_AW        = 10;
	localparam int CNT_W        = 11;
	localparam int MAX_CLUSTERS = 16;
	localparam int CL_W         = 4;
	localparam int NC_W         = 5;
	localparam int ITER_W       = 8;
	localparam int COORD_W      = 16;
	localparam int SUM_W        = 26;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int SQ_W         = 2 * DIFF_W;
	localparam int DIST_W       = SQ_W + 1;
	localparam int STEP_W       = 5;

	localparam logic [1:0] REG_NUM_POINTS     = 2'd0;
	localparam logic [1:0] REG_NUM_CLUSTERS   = 2'd1;
	localparam logic [1:0] REG_NUM_ITERATIONS = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	typedef struct packed {
		logic             mem_we;
		logic             mem_re;
		logic [PT_AW-1:0] pt_addr;
		logic             seed_we;
		logic [CL_W-1:0]  clu;
		logic             diff;
		logic             sq;
		logic             cmp;
		logic             cmp_first;
		logic             acc;
		logic             clr_sums;
		logic             div_start;
		logic             cent_upd;
		logic             emit;
		logic             emit_last;
	} cmd_t;

	typedef struct packed {
		logic            div_done;
		logic            cnt_zero;
		logic [CL_W-1:0] best;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/km2d_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module km2d_div import km2d_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [SUM_W-1:0]   num_x,
	input  wire logic signed [SUM_W-1:0]   num_y,
	input  wire logic        [CNT_W-1:0]   den,
	output logic                           done,
	output logic signed      [COORD_W-1:0] quo_x,
	output logic signed      [COORD_W-1:0] quo_y
);

	logic              busy_q, done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  ax_q, ay_q;
	logic [CNT_W-1:0]  rx_q, ry_q, den_q;
	logic              negx_q, negy_q;
	logic [SUM_W-1:0]  magx, magy, resx, resy;
	logic [CNT_W:0]    trx, try_, subx, suby;
	logic              bx, by;

	// restoring division, one quotient bit per cycle per lane
	always_comb begin
		magx = num_x[SUM_W-1] ? SUM_W'(-num_x) : SUM_W'(num_x);
		magy = num_y[SUM_W-1] ? SUM_W'(-num_y) : SUM_W'(num_y);
		trx  = {rx_q, ax_q[SUM_W-1]};
		try_ = {ry_q, ay_q[SUM_W-1]};
		bx   = trx >= {1'b0, den_q};
		by   = try_ >= {1'b0, den_q};
		subx = bx ? trx - {1'b0, den_q} : trx;
		suby = by ? try_ - {1'b0, den_q} : try_;
		resx = negx_q ? SUM_W'(-ax_q) : ax_q;
		resy = negy_q ? SUM_W'(-ay_q) : ay_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ax_q   <= magx;
			ay_q   <= magy;
			rx_q   <= '0;
			ry_q   <= '0;
			den_q  <= den;
			negx_q <= num_x[SUM_W-1];
			negy_q <= num_y[SUM_W-1];
		end else if (busy_q) begin
			ax_q <= {ax_q[SUM_W-2:0], bx};
			ay_q <= {ay_q[SUM_W-2:0], by};
			rx_q <= subx[CNT_W-1:0];
			ry_q <= suby[CNT_W-1:0];
		end
	end

	assign done  = done_q;
	assign quo_x = resx[COORD_W-1:0];
	assign quo_y = resy[COORD_W-1:0];

endmodule
`default_nettype wire

@@ rtl/km2d_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module km2d_datapath import km2d_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cmd_t                      cmd,
	output sts_t                           sts,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	output logic                           result_strobe,
	output logic             [CL_W-1:0]    cluster_index,
	output logic signed      [COORD_W-1:0] centroid_x,
	output logic signed      [COORD_W-1:0] centroid_y,
	output logic             [CNT_W-1:0]   member_count,
	output logic                           last
);

	logic [2*COORD_W-1:0] pt_mem [MAX_POINTS];
	logic [2*COORD_W-1:0] rdata_q;

	logic signed [COORD_W-1:0] cx_q [MAX_CLUSTERS];
	logic signed [COORD_W-1:0] cy_q [MAX_CLUSTERS];
	logic signed [SUM_W-1:0]   sx_q [MAX_CLUSTERS];
	logic signed [SUM_W-1:0]   sy_q [MAX_CLUSTERS];
	logic        [CNT_W-1:0]   cnt_q [MAX_CLUSTERS];

	logic signed [COORD_W-1:0] px, py;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;
	logic        [SQ_W-1:0]    sqx_s2, sqy_s2;
	logic        [DIST_W-1:0]  sq_sum, best_dist_q;
	logic        [CL_W-1:0]    best_q;

	logic                      div_done;
	logic signed [COORD_W-1:0] qx, qy;

	logic                      strobe_q, last_q;
	logic [CL_W-1:0]           idx_q;
	logic signed [COORD_W-1:0] ox_q, oy_q;
	logic [CNT_W-1:0]          ocnt_q;

	assign px = rdata_q[2*COORD_W-1:COORD_W];
	assign py = rdata_q[COORD_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			pt_mem[cmd.pt_addr] <= {point_x, point_y};
		if (cmd.mem_re)
			rdata_q <= pt_mem[cmd.pt_addr];
	end

	assign sq_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dx_s1 <= DIFF_W'(px) - DIFF_W'(cx_q[cmd.clu]);
			dy_s1 <= DIFF_W'(py) - DIFF_W'(cy_q[cmd.clu]);
		end
		if (cmd.sq) begin
			sqx_s2 <= SQ_W'(dx_s1 * dx_s1);
			sqy_s2 <= SQ_W'(dy_s1 * dy_s1);
		end
		// strict compare keeps the lowest index on a tie
		if (cmd.cmp && (cmd.cmp_first || sq_sum < best_dist_q)) begin
			best_dist_q <= sq_sum;
			best_q      <= cmd.clu;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_we) begin
			cx_q[cmd.clu] <= px;
			cy_q[cmd.clu] <= py;
		end
		if (cmd.cent_upd) begin
			cx_q[cmd.clu] <= qx;
			cy_q[cmd.clu] <= qy;
		end
		if (cmd.clr_sums) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				sx_q[i]  <= '0;
				sy_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else if (cmd.acc) begin
			sx_q[cmd.clu]  <= sx_q[cmd.clu] + SUM_W'(px);
			sy_q[cmd.clu]  <= sy_q[cmd.clu] + SUM_W'(py);
			cnt_q[cmd.clu] <= cnt_q[cmd.clu] + 1'b1;
		end
	end

	km2d_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num_x (sx_q[cmd.clu]),
		.num_y (sy_q[cmd.clu]),
		.den   (cnt_q[cmd.clu]),
		.done  (div_done),
		.quo_x (qx),
		.quo_y (qy)
	);

	assign sts.div_done = div_done;
	assign sts.cnt_zero = cnt_q[cmd.clu] == '0;
	assign sts.best     = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			idx_q  <= cmd.clu;
			ox_q   <= cx_q[cmd.clu];
			oy_q   <= cy_q[cmd.clu];
			ocnt_q <= cnt_q[cmd.clu];
			last_q <= cmd.emit_last;
		end
	end

	assign result_strobe = strobe_q;
	assign cluster_index = idx_q;
	assign centroid_x    = ox_q;
	assign centroid_y    = oy_q;
	assign member_count  = ocnt_q;
	assign last          = last_q;

endmodule
`default_nettype wire

@@ rtl/km2d_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module km2d_ctrl import km2d_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               opcode,
	output logic                    busy,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CNT_W-1:0]   cfg_wdata,
	output cmd_t                    cmd,
	input  wire sts_t               sts
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_SEED_RD  = 12'b0000_0000_0010,
		S_SEED_WR  = 12'b0000_0000_0100,
		S_RND      = 12'b0000_0000_1000,
		S_PT_RD    = 12'b0000_0001_0000,
		S_DIFF     = 12'b0000_0010_0000,
		S_SQ       = 12'b0000_0100_0000,
		S_CMP      = 12'b0000_1000_0000,
		S_ACC      = 12'b0001_0000_0000,
		S_DIV_GO   = 12'b0010_0000_0000,
		S_DIV_WAIT = 12'b0100_0000_0000,
		S_OUT      = 12'b1000_0000_0000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  np_q, loaded_q, n_eff;
	logic [NC_W-1:0]   nc_q, k_sat, k_eff;
	logic [ITER_W-1:0] ni_q, it_eff, iter_q;
	logic [PT_AW-1:0]  p_q;
	logic [CL_W-1:0]   c_q;
	logic              last_c, last_p, last_it;

	always_comb begin
		if (np_q == '0)
			n_eff = CNT_W'(1);
		else if (np_q > CNT_W'(MAX_POINTS))
			n_eff = CNT_W'(MAX_POINTS);
		else
			n_eff = np_q;
		if (nc_q == '0)
			k_sat = NC_W'(1);
		else if (nc_q > NC_W'(MAX_CLUSTERS))
			k_sat = NC_W'(MAX_CLUSTERS);
		else
			k_sat = nc_q;
		k_eff   = (CNT_W'(k_sat) > n_eff) ? n_eff[NC_W-1:0] : k_sat;
		it_eff  = (ni_q == '0) ? ITER_W'(1) : ni_q;
		last_c  = {1'b0, c_q} == k_eff - 1'b1;
		last_p  = {1'b0, p_q} == n_eff - 1'b1;
		last_it = iter_q == it_eff - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q <= CNT_W'(MAX_POINTS);
			nc_q <= NC_W'(4);
			ni_q <= ITER_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_POINTS:     np_q <= cfg_wdata;
				REG_NUM_CLUSTERS:   nc_q <= cfg_wdata[NC_W-1:0];
				REG_NUM_ITERATIONS: ni_q <= cfg_wdata[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.clu       = c_q;
		cmd.cmp_first = c_q == '0;
		cmd.emit_last = last_c;
		unique case (state_q)
			S_IDLE: begin
				cmd.pt_addr = loaded_q[PT_AW-1:0];
				cmd.mem_we  = start && opcode == OP_LOAD && loaded_q < n_eff;
			end
			S_SEED_RD: begin
				cmd.pt_addr = PT_AW'(c_q);
				cmd.mem_re  = 1'b1;
			end
			S_SEED_WR:  cmd.seed_we  = 1'b1;
			S_RND:      cmd.clr_sums = 1'b1;
			S_PT_RD: begin
				cmd.pt_addr = p_q;
				cmd.mem_re  = 1'b1;
			end
			S_DIFF:     cmd.diff = 1'b1;
			S_SQ:       cmd.sq   = 1'b1;
			S_CMP:      cmd.cmp  = 1'b1;
			S_ACC: begin
				cmd.clu = sts.best;
				cmd.acc = 1'b1;
			end
			S_DIV_GO:   cmd.div_start = !sts.cnt_zero;
			S_DIV_WAIT: cmd.cent_upd  = sts.div_done;
			S_OUT:      cmd.emit      = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			loaded_q <= '0;
			p_q      <= '0;
			c_q      <= '0;
			iter_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (opcode == OP_LOAD) begin
							if (loaded_q < n_eff)
								loaded_q <= loaded_q + 1'b1;
						end else if (loaded_q >= n_eff) begin
							c_q     <= '0;
							state_q <= S_SEED_RD;
						end
					end
				end
				S_SEED_RD: state_q <= S_SEED_WR;
				S_SEED_WR: begin
					if (last_c) begin
						iter_q  <= '0;
						state_q <= S_RND;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_SEED_RD;
					end
				end
				S_RND: begin
					p_q     <= '0;
					state_q <= S_PT_RD;
				end
				S_PT_RD: begin
					c_q     <= '0;
					state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_SQ;
				S_SQ:   state_q <= S_CMP;
				S_CMP: begin
					if (last_c)
						state_q <= S_ACC;
					else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_DIFF;
					end
				end
				S_ACC: begin
					if (last_p) begin
						c_q     <= '0;
						state_q <= S_DIV_GO;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_PT_RD;
					end
				end
				S_DIV_GO, S_DIV_WAIT: begin
					if (state_q == S_DIV_GO && !sts.cnt_zero)
						state_q <= S_DIV_WAIT;
					else if (state_q == S_DIV_GO || sts.div_done) begin
						if (!last_c) begin
							c_q     <= c_q + 1'b1;
							state_q <= S_DIV_GO;
						end else if (last_it) begin
							c_q     <= '0;
							state_q <= S_OUT;
						end else begin
							iter_q  <= iter_q + 1'b1;
							state_q <= S_RND;
						end
					end
				end
				S_OUT: begin
					if (last_c)
						state_q <= S_IDLE;
					else
						c_q <= c_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;

	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> {1'b0, c_q} < k_eff)
		else $error("cluster counter beyond cluster count");
	a_acc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> ({1'b0, p_q} < n_eff && {1'b0, sts.best} < k_eff))
		else $error("accumulate outside point or cluster range");
	a_loaded_cap: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CNT_W'(MAX_POINTS))
		else $error("loaded count overflow");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.emit_last |=> state_q == S_IDLE)
		else $error("final result did not end the run");

endmodule
`default_nettype wire

@@ rtl/kmeans_2d_clustering.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-dimensional k-means (Lloyd) on signed Q1.14 points. Pulse start with
// opcode 0 to load one point word (one per cycle, busy stays low); loads past
// the configured point count are dropped. Start with opcode 1 runs clustering
// once all points are loaded (otherwise the word is dropped): centroids seed
// from the first k points (k from the cluster count register), then
// num_iterations rounds of nearest-centroid assignment (lowest index wins
// ties) and truncated-mean update run; an empty cluster holds its centroid.
// Busy is high for the whole run. The distance unit takes one centroid at a
// time through its difference, square and compare steps, and each non-empty
// centroid update waits on a 26-step divider.
// Results come one per cycle on result_strobe, in cluster order, the final one
// with last set. The receiver cannot stall them: capture every strobed word.
// Write configuration only while busy is low.
module kmeans_2d_clustering import km2d_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      opcode,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic                      cfg_we,
	input  wire logic        [1:0]         cfg_index,
	input  wire logic        [CNT_W-1:0]   cfg_wdata,
	output logic                           result_strobe,
	output logic             [CL_W-1:0]    cluster_index,
	output logic signed      [COORD_W-1:0] centroid_x,
	output logic signed      [COORD_W-1:0] centroid_y,
	output logic             [CNT_W-1:0]   member_count,
	output logic                           last
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: load count, config registers, round and point loops
	km2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.opcode   (opcode),
		.busy     (busy),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// point memory, centroids, distance pipe, sums and divider
	km2d_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.point_x      (point_x),
		.point_y      (point_y),
		.result_strobe(result_strobe),
		.cluster_index(cluster_index),
		.centroid_x   (centroid_x),
		.centroid_y   (centroid_y),
		.member_count (member_count),
		.last         (last)
	);

endmodule
`default_nettype wire
